// File: rtl/sal_pkg.sv
`default_nettype none
package sal_pkg;

  localparam int DEPTH_DEF       = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths on the ports
  localparam int IN_VAL_W   = 32;
  localparam int OP_W       = 2;
  localparam int POS_W      = 3;
  localparam int CNT_W      = 4;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_CLEAR  = 2'd3
  } sal_op_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } sal_cmd_t;

endpackage
`default_nettype wire

// File: rtl/sal_cell.sv
`default_nettype none
module sal_cell
  import sal_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire sal_cmd_t                      cmd,
  input  wire logic signed [VALUE_WIDTH-1:0] key,
  input  wire logic                          occ,
  input  wire logic                          left_lt,
  input  wire logic signed [VALUE_WIDTH-1:0] left_val,
  input  wire logic signed [VALUE_WIDTH-1:0] right_val,
  output logic signed [VALUE_WIDTH-1:0]      val,
  output logic                               lt,
  output logic                               bnd,
  output logic                               hit
);

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] val_nxt;

  assign val = val_r;
  // Held entry sorts strictly below the key
  assign lt  = occ && (val_r < key);
  // First cell whose entry is not below the key
  assign bnd = !lt && left_lt;
  assign hit = bnd && occ && (val_r == key);

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (!lt) begin
        val_nxt = left_lt ? key : left_val;
      end
    end else if (cmd.del) begin
      if (!lt) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/sorted_array_list_core.sv
// Sorted list core: one item accepted per cycle when the output is free or being taken.
// The result is registered and shows on out_tvalid in the cycle after input accept.
// Throughput: 1 item per cycle; every cell compares and shifts in the same cycle.
// Reset (rst_n low, synchronous): list empty, no result pending.
// Entry storage has no reset; only entries below the fill count take part in the compares.
`default_nettype none
module sorted_array_list_core
  import sal_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_VAL_W-1:0]   in_tdata,   // [31:0] value
  input  wire logic [OP_W-1:0]       in_tuser,   // [1:0] opcode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // [0] ok, [3:1] position, [7:4] count
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [FW-1:0]             fill_r;
  logic [FW-1:0]             fill_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic [OUT_DATA_W-1:0]     out_data_nxt;

  logic                      accept;
  sal_op_t                   op;
  logic signed [IN_VAL_W-1:0]    in_value;
  logic signed [VALUE_WIDTH-1:0] key;
  logic                      full;
  logic                      found;
  logic [PW-1:0]             pos_enc;
  logic                      ok;
  logic [PW-1:0]             pos;
  sal_cmd_t                  cmd;

  logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]          cell_lt;
  logic [DEPTH-1:0]          cell_bnd;
  logic [DEPTH-1:0]          cell_hit;

  // Take a new item whenever the result register is empty or draining
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign op         = sal_op_t'(in_tuser);
  assign in_value   = in_tdata;
  // Truncate or sign-extend the value to the cell width
  assign key        = VALUE_WIDTH'(in_value);
  assign full       = (fill_r == FW'(DEPTH));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Row of cells: each sees its neighbors' entries and the left cell's compare
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          occ;
    logic                          left_lt;
    logic signed [VALUE_WIDTH-1:0] left_val;
    logic signed [VALUE_WIDTH-1:0] right_val;

    assign occ = (FW'(i) < fill_r);

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = key;
    end else begin : g_mid
      assign left_lt  = cell_lt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sal_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .key      (key),
      .occ      (occ),
      .left_lt  (left_lt),
      .left_val (left_val),
      .right_val(right_val),
      .val      (cell_val[i]),
      .lt       (cell_lt[i]),
      .bnd      (cell_bnd[i]),
      .hit      (cell_hit[i])
    );
  end

  // Boundary is one-hot (or empty when the list is full and every entry is below the key):
  // OR the cell indexes together to get its position
  always_comb begin
    pos_enc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_bnd[i]) begin
        pos_enc = pos_enc | PW'(i);
      end
    end
  end

  assign found = |cell_hit;

  // Decode the operation, drive the cell command and the next fill count
  always_comb begin
    fill_nxt = fill_r;
    ok       = 1'b0;
    pos      = '0;
    cmd      = '0;
    if (accept) begin
      case (op)
        OP_INSERT: begin
          if (!full) begin
            cmd.ins  = 1'b1;
            fill_nxt = fill_r + FW'(1);
            ok       = 1'b1;
            pos      = pos_enc;
          end
        end
        OP_DELETE: begin
          if (found) begin
            cmd.del  = 1'b1;
            fill_nxt = fill_r - FW'(1);
            ok       = 1'b1;
            pos      = pos_enc;
          end
        end
        OP_LOCATE: begin
          if (found) begin
            ok  = 1'b1;
            pos = pos_enc;
          end
        end
        OP_CLEAR: begin
          fill_nxt = '0;
          ok       = 1'b1;
        end
        default: begin
          fill_nxt = fill_r;
        end
      endcase
    end
  end

  // Result register: load on accept, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_tready) begin
      out_valid_nxt = accept;
    end
    if (accept) begin
      out_data_nxt = {CNT_W'(fill_nxt), POS_W'(pos), ok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/sal_checker.sv
`default_nettype none
module sal_checker
  import sal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [OP_W-1:0]       in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Refused or missed operations report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("position not zero on failed operation");

  // Clear yields ok with empty list on the next cycle
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_CLEAR |=>
      out_tvalid && out_tdata[0] && out_tdata[3:1] == 3'd0 && out_tdata[7:4] == 4'd0)
    else $error("clear result wrong");

  // Every accepted item yields a result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing after accept");

  // Count never exceeds the capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[7:4]) <= DEPTH)
    else $error("count above capacity");

endmodule

bind sorted_array_list_core sal_checker #(.DEPTH(DEPTH)) u_sal_checker (.*);
`default_nettype wire
